// ----- sv/supply_voltage_averager_macros.svh -----
// Assertion helpers for the supply voltage averager.
// All checks are clocked on clk and disabled while rst_n is low.
`ifndef SUPPLY_VOLTAGE_AVERAGER_MACROS_SVH
`define SUPPLY_VOLTAGE_AVERAGER_MACROS_SVH

// Same-cycle implication.
`define SVA_CHECK_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("supply_voltage_averager: check failed");

// Next-cycle implication.
`define SVA_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("supply_voltage_averager: check failed");

`endif

// ----- sv/sva_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sva_pkg
// Shared constants and types for the supply voltage averager.
// ----------------------------------------------------------------------------
package sva_pkg;

    localparam int ADC_BITS_DEF = 12;   // default converter resolution
    localparam int SAMPLE_W     = 12;   // sample field width
    localparam int VOLTS_W      = 11;   // volts field width
    localparam int POS_W        = 9;    // sample position counter width
    localparam int CFG_W        = 8;    // config register width

    localparam int VOLT_MUL = 100;
    localparam int VOLT_DIV = 272;
    localparam int VOLT_OFS = 86;
    localparam int VOLT_MAX = 2047;

    localparam logic [CFG_W-1:0] DISCARD_RST = 8'd50;
    localparam logic [CFG_W-1:0] AVERAGE_RST = 8'd100;

    // register index as decoded from paddr[2]
    localparam logic REG_DISCARD = 1'b0;
    localparam logic REG_AVERAGE = 1'b1;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ----- sv/sva_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sva_divider
// Restoring shift-subtract divider, one quotient bit per clock.
// ----------------------------------------------------------------------------
module sva_divider #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_W-1:0]    dividend,
    input  logic [DEN_W-1:0]    divisor,
    output logic [NUM_W-1:0]    quotient,
    output sva_pkg::div_stat_t  stat
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] num_reg;     // dividend shifts out, quotient shifts in
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   diff;
    logic             q_bit;

    always_comb
    begin
        rem_sh = {rem_reg, num_reg[NUM_W-1]};
        diff   = rem_sh - {1'b0, den_reg};
        q_bit  = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], q_bit};
            rem_reg <= q_bit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign quotient  = num_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- sv/supply_voltage_averager.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// supply_voltage_averager
// Cumulative moving average of converter samples, scaled to volts/100.
// ----------------------------------------------------------------------------
// One sample per transaction. A settling sample is dropped without leaving the
// idle state. An averaged sample goes through the multiply and the bit-serial
// divider that forms the running mean (NUM_W = ADC_BITS+10, 22 by default)
// before the next one can be taken. The last sample of a measurement then
// passes the volts scale (multiply by 100, reciprocal multiply, offset and
// clamp) and ST_FINISH, which loads its result into the output register.
// s_tready is low while a sample is in work.
// A pending result does not block the next sample; a second result waits in
// the final state until the first one is taken.
// ----------------------------------------------------------------------------

`include "supply_voltage_averager_macros.svh"

module supply_voltage_averager #(
    parameter int ADC_BITS = sva_pkg::ADC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [11:0] sample, [15:12] zero
    input  logic        s_tuser,    // [0] restart
    // output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [10:0] volts, [15:11] zero
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int POS_W = sva_pkg::POS_W;
    localparam int K_W   = POS_W + 1;
    localparam int NUM_W = ADC_BITS + POS_W + 1;
    localparam int PRD_W = ADC_BITS + POS_W;
    localparam int CFG_W = sva_pkg::CFG_W;
    localparam int VW    = sva_pkg::VOLTS_W;

    // floor(x/VOLT_DIV) as (x*RECIP_M) >> RECIP_SH, exact for any x below 2^X_W
    localparam int X_W      = ADC_BITS + $clog2(sva_pkg::VOLT_MUL);
    localparam int RECIP_SH = X_W + $clog2(sva_pkg::VOLT_DIV);
    localparam int RM_W     = X_W + 1;
    localparam int RP_W     = X_W + RM_W;
    localparam int Q_W      = RP_W - RECIP_SH;
    localparam logic [RM_W-1:0] RECIP_M =
        RM_W'(((64'd1 << RECIP_SH) + 64'(sva_pkg::VOLT_DIV - 1)) / 64'(sva_pkg::VOLT_DIV));

    typedef logic [ADC_BITS-1:0] adc_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_SCALE_MUL,
        ST_SCALE_DIV,
        ST_SCALE_OFS,
        ST_FINISH
    } state_t;

    // ------------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------------
    logic [CFG_W-1:0] discard_reg;
    logic [CFG_W-1:0] average_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discard_reg <= sva_pkg::DISCARD_RST;
            average_reg <= sva_pkg::AVERAGE_RST;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == sva_pkg::REG_DISCARD)
                discard_reg <= pwdata[CFG_W-1:0];
            else
                average_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == sva_pkg::REG_AVERAGE) ? {24'd0, average_reg}
                                                       : {24'd0, discard_reg};

    // ------------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------------
    state_t             state_reg;
    logic [POS_W-1:0]   pos_reg;
    adc_t               mean_reg;
    adc_t               sample_reg;
    logic [K_W-1:0]     k_reg;
    logic [NUM_W-1:0]   prod_reg;
    logic [Q_W-1:0]     scale_q_reg;
    logic [VW-1:0]      volts_reg;
    logic               start_reg;
    logic               m_valid_reg;
    logic [VW-1:0]      m_volts_reg;

    logic [NUM_W-1:0]   quotient;
    sva_pkg::div_stat_t div_stat;

    adc_t               smp_in;
    logic [POS_W-1:0]   pos_eff;
    adc_t               mean_eff;
    logic [K_W-1:0]     k_in;
    logic [CFG_W-1:0]   avg_eff;
    logic [POS_W-1:0]   mul_b;
    logic [PRD_W-1:0]   mul_out;
    logic [NUM_W-1:0]   mul_sum;
    logic [RP_W-1:0]    recip_prod;
    logic [NUM_W-1:0]   volts_sum;
    logic               accept;
    logic               out_free;
    logic               load_out;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign load_out = (state_reg == ST_FINISH) && out_free;

    always_comb
    begin
        smp_in   = adc_t'(s_tdata[sva_pkg::SAMPLE_W-1:0]);
        pos_eff  = s_tuser ? '0 : pos_reg;
        mean_eff = s_tuser ? '0 : mean_reg;
        k_in     = {1'b0, pos_eff} - {{(K_W-CFG_W){1'b0}}, discard_reg} + K_W'(1);
        avg_eff  = (average_reg == '0) ? CFG_W'(1) : average_reg;

        // shared multiplier: mean*(k-1) for the update, mean*100 for the scale
        mul_b    = (state_reg == ST_MUL) ? POS_W'(k_reg - K_W'(1))
                                         : POS_W'(sva_pkg::VOLT_MUL);
        mul_out  = PRD_W'(mean_reg) * PRD_W'(mul_b);
        mul_sum  = NUM_W'(mul_out)
                 + ((state_reg == ST_MUL) ? NUM_W'(sample_reg) : NUM_W'(0));

        recip_prod = RP_W'(prod_reg[X_W-1:0]) * RP_W'(RECIP_M);
        volts_sum  = NUM_W'(scale_q_reg) + NUM_W'(sva_pkg::VOLT_OFS);
    end

    sva_divider #(
        .NUM_W (NUM_W),
        .DEN_W (K_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (prod_reg),
        .divisor  (k_reg),
        .quotient (quotient),
        .stat     (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            mean_reg    <= '0;
            sample_reg  <= '0;
            k_reg       <= '0;
            prod_reg    <= '0;
            scale_q_reg <= '0;
            volts_reg   <= '0;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            m_volts_reg <= '0;
        end
        else
        begin
            start_reg <= (state_reg == ST_MUL);
            if (load_out)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        mean_reg   <= mean_eff;
                        sample_reg <= smp_in;
                        if (pos_eff < {1'b0, discard_reg})
                        begin
                            // settling sample, dropped
                            pos_reg <= pos_eff + POS_W'(1);
                        end
                        else
                        begin
                            pos_reg   <= pos_eff;
                            k_reg     <= k_in;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= mul_sum;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        mean_reg <= quotient[ADC_BITS-1:0];
                        if (k_reg >= {{(K_W-CFG_W){1'b0}}, avg_eff})
                            state_reg <= ST_SCALE_MUL;
                        else
                        begin
                            pos_reg   <= pos_reg + POS_W'(1);
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_SCALE_MUL:
                begin
                    prod_reg  <= mul_sum;
                    state_reg <= ST_SCALE_DIV;
                end
                ST_SCALE_DIV:
                begin
                    scale_q_reg <= recip_prod[RP_W-1:RECIP_SH];
                    state_reg   <= ST_SCALE_OFS;
                end
                ST_SCALE_OFS:
                begin
                    if (volts_sum > NUM_W'(sva_pkg::VOLT_MAX))
                        volts_reg <= VW'(sva_pkg::VOLT_MAX);
                    else
                        volts_reg <= volts_sum[VW-1:0];
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        m_volts_reg <= volts_reg;
                        pos_reg     <= '0;
                        mean_reg    <= '0;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(16-VW){1'b0}}, m_volts_reg};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `SVA_CHECK_NOW(a_ready_div_idle, s_tready, !div_stat.busy)
    `SVA_CHECK_NOW(a_done_in_div, div_stat.done, (state_reg == ST_DIV))
    `SVA_CHECK_NEXT(a_finish_loads, (state_reg == ST_FINISH) && out_free, m_tvalid && s_tready)

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// supply_voltage_averager testbench
// Streams converter samples into the averager and checks every volts result
// against an in-bench model of the settle/average/scale sequence. Registers
// are reprogrammed between runs of samples, including mid-measurement.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 80;     // > worst-case per-sample latency
    localparam int STAGE_A       = 240;    // samples taken before swapping idle rates
    localparam int STAGE_B       = 480;    // samples taken before idling stops

    typedef struct packed {
        logic [sva_pkg::SAMPLE_W-1:0] reading;
        logic                         restart;
    } adc_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // pending samples, expected volts, counters
    adc_item_t                     sample_q[$];
    logic [sva_pkg::VOLTS_W-1:0]   volts_q[$];
    int unsigned                   samples_queued = 0;
    int unsigned                   samples_taken = 0;
    int unsigned                   err_cnt = 0;
    int unsigned                   cycle_cnt = 0;

    // model state and its copy of the registers
    logic [sva_pkg::CFG_W-1:0]     cfg_discard = sva_pkg::DISCARD_RST;
    logic [sva_pkg::CFG_W-1:0]     cfg_average = sva_pkg::AVERAGE_RST;
    logic [sva_pkg::POS_W-1:0]     meas_pos = '0;
    logic [sva_pkg::SAMPLE_W-1:0]  run_mean = '0;

    supply_voltage_averager dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("FAIL supply_voltage_averager");
            $finish;
        end
    end

    // Folds one sample into the measurement; returns 1 when it ends one.
    function automatic bit predict_volts(input logic [sva_pkg::SAMPLE_W-1:0] reading,
                                         input logic restart,
                                         output logic [sva_pkg::VOLTS_W-1:0] volts);
        int unsigned avg_n;
        int unsigned k;
        int unsigned scaled;
        volts = '0;
        avg_n = (cfg_average == 0) ? 1 : cfg_average;
        if (restart)
        begin
            meas_pos = '0;
            run_mean = '0;
        end
        if (meas_pos < cfg_discard)
        begin
            meas_pos = meas_pos + 1'b1;
            return 1'b0;
        end
        k = meas_pos - cfg_discard + 1;
        run_mean = sva_pkg::SAMPLE_W'((int'(run_mean) * (k - 1) + reading) / k);
        if (k < avg_n)
        begin
            meas_pos = meas_pos + 1'b1;
            return 1'b0;
        end
        scaled = int'(run_mean) * sva_pkg::VOLT_MUL / sva_pkg::VOLT_DIV + sva_pkg::VOLT_OFS;
        if (scaled > sva_pkg::VOLT_MAX)
            scaled = sva_pkg::VOLT_MAX;
        volts = scaled[sva_pkg::VOLTS_W-1:0];
        meas_pos = '0;
        run_mean = '0;
        return 1'b1;
    endfunction

    task automatic report_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Sample source and result sink; idle rates follow progress through the run.
    always @(posedge clk)
    begin
        int send_idle;
        int recv_idle;
        adc_item_t nxt;
        if (samples_taken < STAGE_A)
        begin
            send_idle = 34;
            recv_idle = 81;
        end
        else if (samples_taken < STAGE_B)
        begin
            send_idle = 81;
            recv_idle = 34;
        end
        else
        begin
            send_idle = 0;
            recv_idle = 0;
        end
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end
        else
        begin
            if (!s_tvalid || s_tready)
            begin
                if (sample_q.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    nxt = sample_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, nxt.reading};
                    s_tuser  <= nxt.restart;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Result check first, so a sample taken at the same edge cannot satisfy it.
    always @(posedge clk)
    begin
        logic [sva_pkg::VOLTS_W-1:0] want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (volts_q.size() == 0)
                    report_error($sformatf("unexpected result volts=%0d", m_tdata[10:0]));
                else
                begin
                    want = volts_q.pop_front();
                    if (m_tdata[10:0] !== want)
                        report_error($sformatf("volts expected %0d got %0d",
                                               want, m_tdata[10:0]));
                    if (m_tdata[15:11] !== 5'b0)
                        report_error($sformatf("tdata pad expected 0 got 0x%0h",
                                               m_tdata[15:11]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                samples_taken <= samples_taken + 1;
                if (predict_volts(s_tdata[11:0], s_tuser, want))
                    volts_q.push_back(want);
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [sva_pkg::CFG_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'b0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == sva_pkg::REG_DISCARD)
            cfg_discard = value;
        else
            cfg_average = value;
    endtask

    task automatic queue_sample(input logic [sva_pkg::SAMPLE_W-1:0] reading,
                                input logic restart);
        adc_item_t it;
        it.reading = reading;
        it.restart = restart;
        sample_q.push_back(it);
        samples_queued++;
    endtask

    // Settling samples produce no result, so allow the block to finish them too.
    task automatic drain();
        while (samples_taken != samples_queued || volts_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_measurements(input logic [sva_pkg::CFG_W-1:0] discard,
                                    input logic [sva_pkg::CFG_W-1:0] average,
                                    input int count, input int restart_one_in);
        write_reg(sva_pkg::REG_DISCARD, discard);
        write_reg(sva_pkg::REG_AVERAGE, average);
        for (int i = 0; i < count; i++)
            queue_sample(sva_pkg::SAMPLE_W'($urandom_range(4095)),
                         $urandom_range(restart_one_in - 1) == 0);
        drain();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: 50 settling then 100 averaged samples
        for (int i = 0; i < 150; i++)
            queue_sample(sva_pkg::SAMPLE_W'($urandom_range(4095)), 1'b0);
        drain();

        // one-sample measurements with no settling: field extremes
        write_reg(sva_pkg::REG_DISCARD, 8'd0);
        write_reg(sva_pkg::REG_AVERAGE, 8'd1);
        queue_sample(12'd0, 1'b0);
        queue_sample(12'd4095, 1'b0);
        queue_sample(12'hAAA, 1'b1);
        queue_sample(12'h555, 1'b0);
        queue_sample(12'd1, 1'b1);
        queue_sample(12'd2048, 1'b0);
        queue_sample(12'd4094, 1'b0);
        drain();

        // average count of zero behaves as one
        write_reg(sva_pkg::REG_AVERAGE, 8'd0);
        queue_sample(12'd4095, 1'b0);
        queue_sample(12'd7, 1'b0);
        drain();

        // restart in the middle of averaging
        write_reg(sva_pkg::REG_DISCARD, 8'd2);
        write_reg(sva_pkg::REG_AVERAGE, 8'd3);
        queue_sample(12'd100, 1'b0);
        queue_sample(12'd200, 1'b0);
        queue_sample(12'd300, 1'b0);
        queue_sample(12'd400, 1'b1);
        queue_sample(12'd500, 1'b0);
        queue_sample(12'd4095, 1'b0);
        queue_sample(12'd4095, 1'b0);
        queue_sample(12'd4094, 1'b0);
        drain();

        // shrink the average count below the current k mid-measurement
        write_reg(sva_pkg::REG_DISCARD, 8'd0);
        write_reg(sva_pkg::REG_AVERAGE, 8'd8);
        for (int i = 0; i < 5; i++)
            queue_sample(sva_pkg::SAMPLE_W'(3000 + i * 200), 1'b0);
        drain();
        write_reg(sva_pkg::REG_AVERAGE, 8'd2);
        queue_sample(12'd17, 1'b0);
        drain();

        // short random measurements; runs may end mid-measurement
        for (int p = 0; p < 2; p++)
            run_measurements(sva_pkg::CFG_W'($urandom_range(6)),
                             sva_pkg::CFG_W'($urandom_range(8)),
                             $urandom_range(10, 20), 40);

        // register extremes
        run_measurements(8'd255, 8'd1, 256, 1000);
        run_measurements(8'd0, 8'd255, 255, 1000);
        run_measurements(8'd1, 8'd1, 16, 8);

        if (err_cnt == 0 && volts_q.size() == 0)
            $display("PASS supply_voltage_averager");
        else
            $display("FAIL supply_voltage_averager");
        $finish;
    end

endmodule

// ----- supply_voltage_averager.f -----
+incdir+sv
sv/sva_pkg.sv
sv/sva_divider.sv
sv/supply_voltage_averager.sv
tb/testbench.sv
